// ===== hw/rtl/mahd_pkg.sv =====
// Package for the MPEG audio frame header decoder.
// Holds the header codes, the bitrate and sample rate tables, and the
// reciprocals used by the frame length divide. No dependencies.
package mahd_pkg;

    localparam int NUM_W = 26;
    localparam int QUO_W = 11;
    localparam int KMUL_W = 19;
    localparam int RECIP_W = 12;

    localparam logic [10:0] SYNC_PATTERN = 11'h7FF;

    localparam logic [1:0] VBITS_MPEG1 = 2'b11;
    localparam logic [1:0] VBITS_MPEG2 = 2'b10;
    localparam logic [1:0] VBITS_RSVD = 2'b01;
    localparam logic [1:0] VBITS_MPEG25 = 2'b00;

    localparam logic [1:0] VER_MPEG1 = 2'd0;
    localparam logic [1:0] VER_MPEG2 = 2'd1;
    localparam logic [1:0] VER_MPEG25 = 2'd2;

    localparam logic [1:0] LBITS_RSVD = 2'b00;
    localparam logic [1:0] LAYER_NONE = 2'd0;
    localparam logic [1:0] LAYER_I = 2'd1;
    localparam logic [1:0] LAYER_II = 2'd2;
    localparam logic [1:0] LAYER_III = 2'd3;

    localparam logic [1:0] SIDX_RSVD = 2'd3;

    localparam logic [KMUL_W-1:0] K_LAYER_I = 19'd12000;
    localparam logic [KMUL_W-1:0] K_FULL = 19'd144000;
    localparam logic [KMUL_W-1:0] K_HALF = 19'd72000;

    localparam logic [8:0] BR_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
        9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam logic [8:0] BR_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam logic [8:0] BR_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
        9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
    localparam logic [8:0] BR_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam logic [8:0] BR_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
        9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

    typedef struct packed {
        logic        valid_res;
        logic [1:0]  version_code;
        logic [1:0]  layer_number;
        logic        crc_protected;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic        padding_flag;
        logic [1:0]  chan_mode;
        logic [1:0]  mode_ext;
        logic [2:0]  flag_bits;
        logic [1:0]  emphasis;
    } fields_t;

    typedef struct packed {
        logic       ok;
        logic       layer1;
        logic [1:0] rate_sel;
    } len_ctl_t;

    function automatic logic [8:0] bitrate_lookup(input logic [1:0] ver,
                                                  input logic [1:0] layer,
                                                  input logic [3:0] bidx);
        logic [8:0] kbps;
        kbps = '0;
        if (ver == VER_MPEG1) begin
            case (layer)
                LAYER_I:   kbps = BR_V1_L1[bidx];
                LAYER_II:  kbps = BR_V1_L2[bidx];
                LAYER_III: kbps = BR_V1_L3[bidx];
                default:   kbps = '0;
            endcase
        end else begin
            case (layer)
                LAYER_I:   kbps = BR_V2_L1[bidx];
                LAYER_II:  kbps = BR_V2_L23[bidx];
                LAYER_III: kbps = BR_V2_L23[bidx];
                default:   kbps = '0;
            endcase
        end
        return kbps;
    endfunction

    // Base rate of the MPEG-1 family; later versions halve it per step.
    function automatic logic [15:0] rate_base(input logic [1:0] sidx);
        logic [15:0] base;
        case (sidx)
            2'd0:    base = 16'd44100;
            2'd1:    base = 16'd48000;
            2'd2:    base = 16'd32000;
            default: base = 16'd1;
        endcase
        return base;
    endfunction

    // floor(2^26 / base rate), used for the reciprocal divide.
    function automatic logic [RECIP_W-1:0] rate_recip(input logic [1:0] sidx);
        logic [RECIP_W-1:0] recip;
        case (sidx)
            2'd0:    recip = 12'd1521;
            2'd1:    recip = 12'd1398;
            2'd2:    recip = 12'd2097;
            default: recip = '0;
        endcase
        return recip;
    endfunction

endpackage

// ===== hw/rtl/mpeg_audio_header_decoder_top.sv =====
// The decoder takes one header word per transaction and returns one result
// transaction per header; a new header can be accepted in every cycle while in_stall is low.
// The latency is set by the frame length divide, which multiplies by a stored
// reciprocal of the base sample rate and corrects the quotient once, spread
// over four pipeline stages after the field decode. Each stage holds its item
// until the next one is free, so a stall at the output fills the pipeline
// before the input stalls. The block keeps no state between headers.
// Depends on mahd_pkg.
module mpeg_audio_header_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] header_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        valid_res,
    output logic [1:0]  version_code,
    output logic [1:0]  layer_number,
    output logic        crc_protected,
    output logic [8:0]  bitrate_kbps,
    output logic [15:0] sample_rate_hz,
    output logic        padding_flag,
    output logic [1:0]  chan_mode,
    output logic [1:0]  mode_ext,
    output logic [2:0]  flag_bits,
    output logic [1:0]  emphasis,
    output logic [10:0] frame_length
);

    localparam int NW = mahd_pkg::NUM_W;
    localparam int QW = mahd_pkg::QUO_W;
    localparam int KW = mahd_pkg::KMUL_W;
    localparam int RW = mahd_pkg::RECIP_W;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    mahd_pkg::fields_t  f1_reg, f2_reg, f3_reg, f4_reg, f5_reg;
    mahd_pkg::fields_t  f1_next;
    mahd_pkg::len_ctl_t c1_reg, c2_reg, c3_reg, c4_reg;
    mahd_pkg::len_ctl_t c1_next;

    logic [KW-1:0]   kmul1_reg, kmul1_next;
    logic [NW-1:0]   num2_reg, num2_next;
    logic [NW-1:0]   num3_reg;
    logic [QW-1:0]   qest3_reg, qest3_next;
    logic [NW-1:0]   num4_reg;
    logic [QW-1:0]   qest4_reg;
    logic [26:0]     prod4_reg, prod4_next;
    logic [10:0]     flen5_reg, flen5_next;

    assign en5 = !v5_reg || !out_stall;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    // Stage 1: field decode and table lookups.
    always_comb
    begin
        logic        sync;
        logic [1:0]  vbits;
        logic [1:0]  lbits;
        logic [3:0]  bidx;
        logic [1:0]  sidx;
        logic [1:0]  ver;
        logic [1:0]  layer;
        logic        ver_ok;
        logic [8:0]  kbps;
        logic [15:0] rate;
        logic        ok;
        logic [KW-1:0] kconst;

        sync  = (header_word[31:21] == mahd_pkg::SYNC_PATTERN);
        vbits = header_word[20:19];
        lbits = header_word[18:17];
        bidx  = header_word[15:12];
        sidx  = header_word[11:10];

        case (vbits)
            mahd_pkg::VBITS_MPEG1:  ver = mahd_pkg::VER_MPEG1;
            mahd_pkg::VBITS_MPEG2:  ver = mahd_pkg::VER_MPEG2;
            mahd_pkg::VBITS_MPEG25: ver = mahd_pkg::VER_MPEG25;
            default:                ver = mahd_pkg::VER_MPEG1;
        endcase
        ver_ok = (vbits != mahd_pkg::VBITS_RSVD);

        if (lbits == mahd_pkg::LBITS_RSVD)
            layer = mahd_pkg::LAYER_NONE;
        else
            layer = 2'(3'd4 - {1'b0, lbits});

        if (ver_ok && layer != mahd_pkg::LAYER_NONE)
            kbps = mahd_pkg::bitrate_lookup(ver, layer, bidx);
        else
            kbps = '0;

        if (ver_ok && sidx != mahd_pkg::SIDX_RSVD)
            rate = mahd_pkg::rate_base(sidx) >> ver;
        else
            rate = '0;

        ok = sync && ver_ok && (layer != mahd_pkg::LAYER_NONE) && (kbps != '0)
             && (rate != '0)
             && !(ver == mahd_pkg::VER_MPEG25 && layer != mahd_pkg::LAYER_III);

        if (layer == mahd_pkg::LAYER_I)
            kconst = mahd_pkg::K_LAYER_I;
        else if (layer == mahd_pkg::LAYER_III && ver != mahd_pkg::VER_MPEG1)
            kconst = mahd_pkg::K_HALF;
        else
            kconst = mahd_pkg::K_FULL;

        kmul1_next = ok ? (kconst << ver) : '0;

        c1_next.ok       = ok;
        c1_next.layer1   = (layer == mahd_pkg::LAYER_I);
        c1_next.rate_sel = sidx;

        if (sync) begin
            f1_next.valid_res      = ok;
            f1_next.version_code   = ver;
            f1_next.layer_number   = layer;
            f1_next.crc_protected  = !header_word[16];
            f1_next.bitrate_kbps   = kbps;
            f1_next.sample_rate_hz = rate;
            f1_next.padding_flag   = header_word[9];
            f1_next.chan_mode      = header_word[7:6];
            f1_next.mode_ext       = header_word[5:4];
            f1_next.flag_bits      = {header_word[8], header_word[3], header_word[2]};
            f1_next.emphasis       = header_word[1:0];
        end else begin
            f1_next = '0;
        end
    end

    // Stage 2: numerator of the frame length quotient.
    always_comb
    begin
        logic [27:0] prod;
        prod = 28'(f1_reg.bitrate_kbps) * 28'(kmul1_reg);
        num2_next = prod[NW-1:0];
    end

    // Stage 3: quotient estimate from the reciprocal of the base rate.
    always_comb
    begin
        logic [NW+RW-1:0] prod;
        prod = (NW + RW)'(num2_reg) * (NW + RW)'(mahd_pkg::rate_recip(c2_reg.rate_sel));
        qest3_next = prod[NW+QW-1:NW];
    end

    // Stage 4: product of the estimate and the divisor.
    assign prod4_next = 27'(qest3_reg) * 27'(mahd_pkg::rate_base(c3_reg.rate_sel));

    // Stage 5: one-step correction, padding, and the Layer I slot size.
    always_comb
    begin
        logic [NW-1:0] rem;
        logic [QW-1:0] quo;
        logic [QW-1:0] sum;

        rem = num4_reg - prod4_reg[NW-1:0];
        quo = qest4_reg + QW'(rem >= NW'(mahd_pkg::rate_base(c4_reg.rate_sel)));
        sum = quo + QW'(f4_reg.padding_flag);
        if (!c4_reg.ok)
            flen5_next = '0;
        else if (c4_reg.layer1)
            flen5_next = {sum[8:0], 2'b00};
        else
            flen5_next = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
            if (en5)
                v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) begin
            f1_reg    <= f1_next;
            c1_reg    <= c1_next;
            kmul1_reg <= kmul1_next;
        end
        if (en2) begin
            f2_reg   <= f1_reg;
            c2_reg   <= c1_reg;
            num2_reg <= num2_next;
        end
        if (en3) begin
            f3_reg    <= f2_reg;
            c3_reg    <= c2_reg;
            num3_reg  <= num2_reg;
            qest3_reg <= qest3_next;
        end
        if (en4) begin
            f4_reg    <= f3_reg;
            c4_reg    <= c3_reg;
            num4_reg  <= num3_reg;
            qest4_reg <= qest3_reg;
            prod4_reg <= prod4_next;
        end
        if (en5) begin
            f5_reg    <= f4_reg;
            flen5_reg <= flen5_next;
        end
    end

    assign out_valid      = v5_reg;
    assign valid_res      = f5_reg.valid_res;
    assign version_code   = f5_reg.version_code;
    assign layer_number   = f5_reg.layer_number;
    assign crc_protected  = f5_reg.crc_protected;
    assign bitrate_kbps   = f5_reg.bitrate_kbps;
    assign sample_rate_hz = f5_reg.sample_rate_hz;
    assign padding_flag   = f5_reg.padding_flag;
    assign chan_mode      = f5_reg.chan_mode;
    assign mode_ext       = f5_reg.mode_ext;
    assign flag_bits      = f5_reg.flag_bits;
    assign emphasis       = f5_reg.emphasis;
    assign frame_length   = flen5_reg;

endmodule

// ===== hw/rtl/mahd_checker.sv =====
// Port-level checks for the MPEG audio header decoder, bound to its top level.
// Depends on mahd_pkg and the ports of mpeg_audio_header_decoder_top.
module mahd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [31:0] header_word,
    input logic        out_valid,
    input logic        out_stall,
    input logic        valid_res,
    input logic [1:0]  version_code,
    input logic [1:0]  layer_number,
    input logic        crc_protected,
    input logic [8:0]  bitrate_kbps,
    input logic [15:0] sample_rate_hz,
    input logic        padding_flag,
    input logic [1:0]  chan_mode,
    input logic [1:0]  mode_ext,
    input logic [2:0]  flag_bits,
    input logic [1:0]  emphasis,
    input logic [10:0] frame_length
);

    a_invalid_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (frame_length == 11'd0))
        else $error("Rejected header carries a nonzero frame length.");

    a_valid_has_rates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res) |->
            (bitrate_kbps != 9'd0 && sample_rate_hz != 16'd0 && frame_length != 11'd0))
        else $error("Accepted header has a zero bitrate, sample rate or length.");

    a_layer1_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && valid_res && layer_number == mahd_pkg::LAYER_I)
            |-> (frame_length[1:0] == 2'b00))
        else $error("Layer I frame length is not a whole number of slots.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(frame_length)
            && $stable(bitrate_kbps)))
        else $error("Stalled result transaction changed or vanished.");

endmodule

bind mpeg_audio_header_decoder_top mahd_checker u_mahd_checker (.*);
